[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that cond implies prop in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

[rtl/bkpa_pkg.sv]
// ----------------------------------------------------------------------------
// bkpa_pkg
// Shared constants and types for the Koblitz point arithmetic block.
// ----------------------------------------------------------------------------
package bkpa_pkg;
   localparam int FLD_BITS    = 19;
   localparam int SCALAR_BITS = 19;
   localparam int CNT_BITS    = $clog2(FLD_BITS + 1);
   // Low part of the reduction polynomial x^19 + x^5 + x^2 + x + 1.
   localparam logic [FLD_BITS-1:0] FLD_POLY_LO = FLD_BITS'(39);
   localparam logic [FLD_BITS-1:0] FLD_ONE     = FLD_BITS'(1);

   // Operation codes carried by the action field.
   localparam logic ACT_ADD = 1'b0;
   localparam logic ACT_MUL = 1'b1;

   typedef logic [FLD_BITS-1:0] fld_type;

   typedef struct packed {
      logic    start;
      fld_type a;
      fld_type b;
   } mul_req_type;
endpackage

[rtl/bkpa_mul.sv]
// ----------------------------------------------------------------------------
// bkpa_mul
// Bit-serial GF(2^19) multiplier: one bit of b per cycle, LSB first.
// ----------------------------------------------------------------------------
module bkpa_mul import bkpa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type mul_req,
   output logic        mul_done,
   output fld_type     mul_z
);
   fld_type a_ff, a_in, b_ff, b_in, z_ff, z_in;
   logic    busy_ff, busy_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   fld_type a_sh;

   always_comb begin
      a_in = a_ff; b_in = b_ff; z_in = z_ff; busy_in = busy_ff; cnt_in = cnt_ff;
      a_sh = {a_ff[FLD_BITS-2:0], 1'b0} ^ (a_ff[FLD_BITS-1] ? FLD_POLY_LO : '0);
      if (mul_req.start) begin
         a_in = mul_req.a; b_in = mul_req.b; z_in = '0; busy_in = 1'b1;
         cnt_in = CNT_BITS'(FLD_BITS);
      end else if (busy_ff) begin
         if (b_ff[0]) z_in = z_ff ^ a_ff;
         a_in   = a_sh;
         b_in   = b_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in; b_ff <= b_in; z_ff <= z_in; cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   assign mul_done = busy_ff && (cnt_ff == CNT_BITS'(1));
   assign mul_z    = b_ff[0] ? (z_ff ^ a_ff) : z_ff;
endmodule

[rtl/binary_koblitz_point_arithmetic.sv]
// ----------------------------------------------------------------------------
// binary_koblitz_point_arithmetic
// Affine point add and scalar multiply on a Koblitz curve over GF(2^19).
// ----------------------------------------------------------------------------
// Cost: every field multiply runs in the bit-serial multiplier, which is the
// only arithmetic unit. An inversion is 36 multiplies, a point operation
// about 40, and a scalar multiply up to about 38 point operations. One
// word at a time.
// Reset is synchronous and returns the sequencer to idle with no word held.
`include "assert_macros.svh"
module binary_koblitz_point_arithmetic import bkpa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [18:0] req_p_x,
   input  logic [18:0] req_p_y,
   input  logic        req_p_inf,
   input  logic [18:0] req_q_x,
   input  logic [18:0] req_q_y,
   input  logic        req_q_inf,
   input  logic [18:0] req_scalar,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [18:0] rsp_r_x,
   output logic [18:0] rsp_r_y,
   output logic        rsp_r_inf,
   output logic        rsp_fault
);
   // Sequencer states.
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SEL   = 4'd1;  // pick next point op or finish
   localparam logic [3:0] S_ADD   = 4'd2;  // classify operands of u+v
   localparam logic [3:0] S_INV   = 4'd3;  // exponentiation ladder
   localparam logic [3:0] S_LAM   = 4'd4;  // lambda = num * inv (+ x when doubling)
   localparam logic [3:0] S_SQ    = 4'd5;  // lambda^2
   localparam logic [3:0] S_Y1    = 4'd6;  // y multiply
   localparam logic [3:0] S_Y2    = 4'd7;  // doubling: x^2
   localparam logic [3:0] S_DONE  = 4'd8;  // step to doubling, next bit or output
   localparam logic [3:0] S_OUT   = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       mode_ff, mode_in;        // ACT_MUL = scalar
   logic       addq_ff, addq_in;        // current op is z+p (else p+p)
   logic       dbl_ff, dbl_in;
   logic [SCALAR_BITS-1:0] k_ff, k_in;
   // Accumulator z and base p.
   fld_type zx_ff, zx_in, zy_ff, zy_in, px_ff, px_in, py_ff, py_in;
   logic    zi_ff, zi_in, pi_ff, pi_in;
   // Operands of the current add u + v and working values.
   fld_type ux_ff, ux_in, uy_ff, uy_in, vx_ff, vx_in, vy_ff, vy_in;
   fld_type base_ff, base_in, acc_ff, acc_in, lam_ff, lam_in, rx_ff, rx_in;
   fld_type t_ff, t_in;
   logic    phase_ff, phase_in;         // inversion: 0 = acc*base, 1 = base^2
   logic [CNT_BITS-1:0] ecnt_ff, ecnt_in;
   logic    go_ff, go_in;
   logic    rv_ff, rv_in, rf_ff, rf_in, ri_ff, ri_in;
   fld_type ox_ff, ox_in, oy_ff, oy_in;
   logic    fault_ff, fault_in;

   mul_req_type mreq;
   logic        mdone;
   fld_type     mz;

   bkpa_mul u_mul (.clock(clock), .reset(reset), .mul_req(mreq), .mul_done(mdone),
      .mul_z(mz));

   assign req_ready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_r_x = ox_ff;
   assign rsp_r_y = oy_ff;
   assign rsp_r_inf = ri_ff;
   assign rsp_fault = rf_ff;

   always_comb begin
      state_in = state_ff; mode_in = mode_ff; addq_in = addq_ff; dbl_in = dbl_ff;
      k_in = k_ff; zx_in = zx_ff; zy_in = zy_ff; zi_in = zi_ff;
      px_in = px_ff; py_in = py_ff; pi_in = pi_ff;
      ux_in = ux_ff; uy_in = uy_ff; vx_in = vx_ff; vy_in = vy_ff;
      base_in = base_ff; acc_in = acc_ff; lam_in = lam_ff; rx_in = rx_ff; t_in = t_ff;
      phase_in = phase_ff; ecnt_in = ecnt_ff; go_in = 1'b0;
      rv_in = rv_ff; rf_in = rf_ff; ri_in = ri_ff; ox_in = ox_ff; oy_in = oy_ff;
      fault_in = fault_ff;
      mreq.start = go_ff; mreq.a = '0; mreq.b = '0;

      // Multiplier operands follow the state.
      unique case (state_ff)
         S_INV: begin
            mreq.a = phase_ff ? base_ff : acc_ff; mreq.b = base_ff;
         end
         S_LAM:   begin mreq.a = t_ff;   mreq.b = acc_ff; end
         S_SQ:    begin mreq.a = lam_ff; mreq.b = lam_ff; end
         // doubling: (lambda+1) * rx; add: lambda * (ux + rx)
         S_Y1:    begin mreq.a = t_ff;   mreq.b = dbl_ff ? rx_ff : (ux_ff ^ rx_ff); end
         S_Y2:    begin mreq.a = ux_ff;  mreq.b = ux_ff;  end
         default: begin mreq.a = '0;     mreq.b = '0;     end
      endcase

      if (rv_ff && rsp_ready) rv_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               mode_in = req_action; fault_in = 1'b0;
               px_in = req_p_x; py_in = req_p_y; pi_in = req_p_inf;
               k_in = req_scalar[SCALAR_BITS-1:0];
               zx_in = '0; zy_in = '0; zi_in = 1'b1;
               if (req_action == ACT_ADD) begin
                  ux_in = req_p_x; uy_in = req_p_y; zi_in = req_p_inf;
                  vx_in = req_q_x; vy_in = req_q_y; pi_in = req_q_inf;
                  zx_in = req_p_x; zy_in = req_p_y;
                  px_in = req_q_x; py_in = req_q_y;
                  addq_in = 1'b1; state_in = S_ADD;
               end else begin
                  state_in = S_SEL;
               end
            end
         end
         S_SEL: begin
            // Finish on an add, when k is zero or when a fault was seen.
            if (mode_ff == ACT_ADD || k_ff == '0 || fault_ff) begin
               state_in = S_OUT;
            end else begin
               addq_in = k_ff[0];
               ux_in = k_ff[0] ? zx_ff : px_ff; uy_in = k_ff[0] ? zy_ff : py_ff;
               vx_in = px_ff; vy_in = py_ff;
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            // u is z (or p for doubling), v is p; handle infinity first.
            if (addq_ff && zi_ff) begin
               zx_in = px_ff; zy_in = py_ff; zi_in = pi_ff; state_in = S_DONE;
            end else if (pi_ff) begin
               state_in = S_DONE; // z + inf = z, p + p stays inf
            end else if (ux_ff == vx_ff) begin
               if ((uy_ff ^ vy_ff) == ux_ff) begin
                  rx_in = '0; t_in = '0; dbl_in = 1'b0; lam_in = '0;
                  if (addq_ff) begin zx_in = '0; zy_in = '0; zi_in = 1'b1; end
                  else begin px_in = '0; py_in = '0; pi_in = 1'b1; end
                  state_in = S_DONE;
               end else if (uy_ff != vy_ff || ux_ff == '0) begin
                  fault_in = 1'b1; state_in = S_DONE;
               end else begin
                  dbl_in = 1'b1; base_in = ux_ff; t_in = uy_ff;
                  acc_in = FLD_ONE; phase_in = 1'b0; ecnt_in = '0;
                  go_in = 1'b0; state_in = S_INV;
                  // exponent 2^19-2: bit0 = 0, so start with squaring.
                  phase_in = 1'b1; go_in = 1'b1;
               end
            end else begin
               dbl_in = 1'b0; base_in = ux_ff ^ vx_ff; t_in = uy_ff ^ vy_ff;
               acc_in = FLD_ONE; ecnt_in = '0; phase_in = 1'b1; go_in = 1'b1;
               state_in = S_INV;
            end
         end
         S_INV: begin
            // Bit i of 2^19-2 is set for i in 1..18: square, then multiply.
            if (mdone) begin
               if (phase_ff) begin
                  base_in = mz; ecnt_in = ecnt_ff + 1'b1;
                  phase_in = 1'b0; go_in = 1'b1;
               end else begin
                  acc_in = mz; go_in = 1'b1;
                  if (ecnt_ff == CNT_BITS'(FLD_BITS - 1)) state_in = S_LAM;
                  else phase_in = 1'b1;
               end
            end
         end
         S_LAM: if (mdone) begin
            lam_in = dbl_ff ? (ux_ff ^ mz) : mz;
            go_in = 1'b1; state_in = S_SQ;
         end
         S_SQ: if (mdone) begin
            rx_in = dbl_ff ? (mz ^ lam_ff ^ FLD_ONE)
                           : (mz ^ lam_ff ^ ux_ff ^ vx_ff ^ FLD_ONE);
            t_in = dbl_ff ? (lam_ff ^ FLD_ONE) : lam_ff;
            go_in = 1'b1; state_in = S_Y1;
         end
         S_Y1: if (mdone) begin
            // add: y = l*(ux^rx) ^ rx ^ uy, no further multiply needed.
            if (dbl_ff) begin
               t_in = mz; go_in = 1'b1; state_in = S_Y2;
            end else begin
               t_in = mz; state_in = S_Y2;
            end
         end
         S_Y2: begin
            if (!dbl_ff || mdone) begin
               if (addq_ff) begin
                  zx_in = rx_ff; zi_in = 1'b0;
                  zy_in = dbl_ff ? (mz ^ t_ff) : (t_ff ^ rx_ff ^ uy_ff);
               end else begin
                  px_in = rx_ff; pi_in = 1'b0;
                  py_in = dbl_ff ? (mz ^ t_ff) : (t_ff ^ rx_ff ^ uy_ff);
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (mode_ff == ACT_ADD) state_in = S_OUT;
            else if (addq_ff) begin
               // Now double p.
               addq_in = 1'b0; ux_in = px_ff; uy_in = py_ff;
               vx_in = px_ff; vy_in = py_ff; state_in = S_ADD;
            end else begin
               k_in = k_ff >> 1; state_in = S_SEL;
            end
         end
         S_OUT: begin
            if (!rv_ff) begin
               rv_in = 1'b1; rf_in = fault_ff;
               ri_in = !fault_ff && zi_ff;
               ox_in = (fault_ff || zi_ff) ? '0 : zx_ff;
               oy_in = (fault_ff || zi_ff) ? '0 : zy_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in; zx_ff <= zx_in; zy_ff <= zy_in; zi_ff <= zi_in;
      px_ff <= px_in; py_ff <= py_in; pi_ff <= pi_in; mode_ff <= mode_in;
      ux_ff <= ux_in; uy_ff <= uy_in; vx_ff <= vx_in; vy_ff <= vy_in;
      base_ff <= base_in; acc_ff <= acc_in; lam_ff <= lam_in; t_ff <= t_in;
      rx_ff <= rx_in;
      addq_ff <= addq_in; dbl_ff <= dbl_in; phase_ff <= phase_in; ecnt_ff <= ecnt_in;
      ox_ff <= ox_in; oy_ff <= oy_in; ri_ff <= ri_in; rf_ff <= rf_in;
      if (reset) begin
         state_ff <= S_IDLE; go_ff <= 1'b0; rv_ff <= 1'b0; fault_ff <= 1'b0;
      end else begin
         state_ff <= state_in; go_ff <= go_in; rv_ff <= rv_in; fault_ff <= fault_in;
      end
   end

   `ASSERT_CLK(a_ready_idle, clock, reset, !(req_ready && state_ff != S_IDLE), "ready out of idle")
   `ASSERT_CLK(a_fault_excl, clock, reset, !(rv_ff && rf_ff && ri_ff), "fault with infinity")
   `ASSERT_NEXT(a_acc_busy, clock, reset, req_valid && req_ready, state_ff != S_IDLE, "no start")
endmodule

[sim/binary_koblitz_point_arithmetic_tb.sv]
// ----------------------------------------------------------------------------
// binary_koblitz_point_arithmetic_tb
// Self-checking bench for Koblitz point add and scalar multiply. Directed
// corner words come from a table, then random words, many built from curve
// points. Results are checked against the row's typed result or a GF(2^19) model.
// ----------------------------------------------------------------------------
module binary_koblitz_point_arithmetic_tb import bkpa_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic    action;
      fld_type p_x;
      fld_type p_y;
      logic    p_inf;
      fld_type q_x;
      fld_type q_y;
      logic    q_inf;
      fld_type scalar;
   } op_word_type;

   typedef struct packed {
      fld_type x;
      fld_type y;
      logic    inf;
      logic    fault;
   } point_res_type;

   typedef struct packed {
      fld_type x;
      fld_type y;
      logic    inf;
   } ec_point_type;

   // Directed row: chk set means the expected result is typed in the row.
   typedef struct packed {
      op_word_type   w;
      logic          chk;
      point_res_type r;
   } dir_row_type;

   localparam point_res_type R_INF   = '{x: '0, y: '0, inf: 1'b1, fault: 1'b0};
   localparam point_res_type R_FAULT = '{x: '0, y: '0, inf: 1'b0, fault: 1'b1};
   localparam point_res_type R_NONE  = '{x: '0, y: '0, inf: 1'b0, fault: 1'b0};
   localparam fld_type       F_MAX   = '1;

   localparam int N_DIR = 14;
   localparam dir_row_type dir_tab [0:N_DIR-1] = '{
      // infinity plus infinity
      '{'{ACT_ADD, F_MAX, F_MAX, 1'b1, F_MAX, F_MAX, 1'b1, '0}, 1'b1, R_INF},
      // P + inf passes P through, all ones
      '{'{ACT_ADD, F_MAX, F_MAX, 1'b0, '0, '0, 1'b1, F_MAX}, 1'b1,
        '{F_MAX, F_MAX, 1'b0, 1'b0}},
      // inf + Q passes Q through
      '{'{ACT_ADD, '0, '0, 1'b1, F_MAX, 19'd0, 1'b0, '0}, 1'b1,
        '{F_MAX, 19'd0, 1'b0, 1'b0}},
      // negation pair: y_P ^ y_Q == x
      '{'{ACT_ADD, 19'd5, 19'd3, 1'b0, 19'd5, 19'd6, 1'b0, '0}, 1'b1, R_INF},
      // doubling with x = 0 lands on infinity
      '{'{ACT_ADD, 19'd0, 19'd1, 1'b0, 19'd0, 19'd1, 1'b0, '0}, 1'b1, R_INF},
      // invalid equal-x pair
      '{'{ACT_ADD, 19'd5, 19'd3, 1'b0, 19'd5, 19'd9, 1'b0, '0}, 1'b1, R_FAULT},
      '{'{ACT_ADD, F_MAX, 19'd1, 1'b0, F_MAX, 19'd2, 1'b0, F_MAX}, 1'b1, R_FAULT},
      // zero scalar
      '{'{ACT_MUL, 19'd3, 19'd5, 1'b0, '0, '0, 1'b0, 19'd0}, 1'b1, R_INF},
      // scalar times infinity
      '{'{ACT_MUL, F_MAX, F_MAX, 1'b1, '0, '0, 1'b0, F_MAX}, 1'b1, R_INF},
      // predicted rows
      '{'{ACT_MUL, 19'd3, 19'd5, 1'b0, '0, '0, 1'b0, F_MAX}, 1'b0, R_NONE},
      '{'{ACT_MUL, 19'd0, 19'd0, 1'b0, '0, '0, 1'b0, 19'd1}, 1'b0, R_NONE},
      '{'{ACT_MUL, 19'd7, 19'd1, 1'b0, '0, '0, 1'b0, 19'd6}, 1'b0, R_NONE},
      '{'{ACT_ADD, 19'd1, F_MAX, 1'b0, F_MAX, 19'd1, 1'b0, '0}, 1'b0, R_NONE},
      '{'{ACT_ADD, 19'd0, 19'd0, 1'b0, 19'd1, 19'd0, 1'b0, '0}, 1'b0, R_NONE}
   };

   logic    clock, reset;
   logic    req_valid, req_ready, req_action, req_p_inf, req_q_inf;
   fld_type req_p_x, req_p_y, req_q_x, req_q_y, req_scalar;
   logic    rsp_valid, rsp_ready, rsp_r_inf, rsp_fault;
   fld_type rsp_r_x, rsp_r_y;

   point_res_type pending_results[$];
   int            err_count;
   bit            stim_done;

   binary_koblitz_point_arithmetic dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------- field and curve model ----------------
   function automatic fld_type gf_mult(fld_type a, fld_type b);
      logic [FLD_BITS:0] sh;
      fld_type           acc;
      acc = '0;
      sh  = {1'b0, a};
      for (int i = 0; i < FLD_BITS; i++) begin
         if (b[i]) acc ^= sh[FLD_BITS-1:0];
         sh = sh << 1;
         if (sh[FLD_BITS]) sh ^= {1'b1, FLD_POLY_LO};
      end
      return acc;
   endfunction

   // a^(2^19 - 2) by square-and-multiply
   function automatic fld_type gf_inverse(fld_type a);
      logic [FLD_BITS:0] e;
      fld_type           acc;
      e   = {1'b0, ~FLD_ONE};
      acc = FLD_ONE;
      while (e != 0) begin
         if (e[0]) acc = gf_mult(acc, a);
         a = gf_mult(a, a);
         e = e >> 1;
      end
      return acc;
   endfunction

   function automatic ec_point_type point_sum(ec_point_type p, ec_point_type q,
                                              inout bit bad);
      ec_point_type r;
      fld_type      lam;
      r = '{'0, '0, 1'b1};
      if (p.inf) return q;
      if (q.inf) return p;
      if (p.x == q.x) begin
         if ((p.y ^ q.y) == p.x) return r;
         if (p.y != q.y || p.x == '0) begin
            bad = 1'b1;
            return r;
         end
         lam = p.x ^ gf_mult(p.y, gf_inverse(p.x));
         r.x = gf_mult(lam, lam) ^ lam ^ FLD_ONE;
         r.y = gf_mult(p.x, p.x) ^ gf_mult(lam ^ FLD_ONE, r.x);
      end else begin
         lam = gf_mult(p.y ^ q.y, gf_inverse(p.x ^ q.x));
         r.x = gf_mult(lam, lam) ^ lam ^ p.x ^ q.x ^ FLD_ONE;
         r.y = gf_mult(lam, p.x ^ r.x) ^ r.x ^ p.y;
      end
      r.inf = 1'b0;
      return r;
   endfunction

   function automatic point_res_type predict_point(op_word_type w);
      ec_point_type p, q, acc;
      bit           bad;
      logic [SCALAR_BITS-1:0] k;
      point_res_type res;
      p   = '{w.p_x, w.p_y, w.p_inf};
      q   = '{w.q_x, w.q_y, w.q_inf};
      bad = 1'b0;
      if (w.action == ACT_MUL) begin
         acc = '{'0, '0, 1'b1};
         k   = w.scalar[SCALAR_BITS-1:0];
         while (k != 0 && !bad) begin
            if (k[0]) acc = point_sum(acc, p, bad);
            p = point_sum(p, p, bad);
            k = k >> 1;
         end
      end else begin
         acc = point_sum(p, q, bad);
      end
      if (bad)          res = R_FAULT;
      else if (acc.inf) res = R_INF;
      else              res = '{acc.x, acc.y, 1'b0, 1'b0};
      return res;
   endfunction

   // Random point on the curve: with y = x*z, solve z^2 + z = x + 1 + 1/x^2 by
   // half-trace, retry when that x has no solution.
   function automatic ec_point_type curve_point();
      fld_type x, c, z, t, lhs, rhs;
      forever begin
         x = FLD_BITS'($urandom_range(1, (1 << FLD_BITS) - 1));
         t = gf_inverse(x);
         c = x ^ FLD_ONE ^ gf_mult(t, t);
         z = '0;
         t = c;
         for (int i = 0; i < 10; i++) begin
            z ^= t;
            t = gf_mult(t, t);
            t = gf_mult(t, t);
         end
         t   = gf_mult(x, z);
         lhs = gf_mult(t, t) ^ gf_mult(x, t);
         rhs = gf_mult(gf_mult(x, x), x) ^ gf_mult(x, x) ^ FLD_ONE;
         if (lhs == rhs) return '{x, t, 1'b0};
      end
   endfunction

   // ---------------- driver ----------------
   task automatic drive_word(op_word_type w, point_res_type want);
      @(negedge clock);
      req_valid  = 1'b1;
      req_action = w.action;
      req_p_x    = w.p_x;
      req_p_y    = w.p_y;
      req_p_inf  = w.p_inf;
      req_q_x    = w.q_x;
      req_q_y    = w.q_y;
      req_q_inf  = w.q_inf;
      req_scalar = w.scalar;
      // hold until the word is taken
      do @(posedge clock); while (!req_ready);
      pending_results = {pending_results, want};
   endtask

   task automatic idle_sender(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
   endtask

   function automatic op_word_type random_word();
      op_word_type  w;
      ec_point_type p, q;
      int           mode;
      logic [127:0] rnd;
      rnd = {$urandom, $urandom, $urandom, $urandom};
      w   = rnd[$bits(op_word_type)-1:0];
      w.p_inf = ($urandom_range(0, 15) == 0);
      w.q_inf = ($urandom_range(0, 15) == 0);
      // keep most scalars short, a few full width, to bound run time
      if ($urandom_range(0, 7) != 0) w.scalar = FLD_BITS'($urandom_range(0, 255));
      mode = int'($urandom_range(0, 9));
      if (mode < 7) begin
         p = curve_point();
         case ($urandom_range(0, 3))
            0: q = p;                              // doubling
            1: q = '{p.x, p.y ^ p.x, 1'b0};        // negation
            default: q = curve_point();
         endcase
         w.p_x = p.x; w.p_y = p.y; w.q_x = q.x; w.q_y = q.y;
      end else if (mode == 7) begin
         w.q_x = w.p_x;                            // equal x, likely fault
      end
      return w;
   endfunction

   initial begin
      op_word_type w;
      int          burst;
      int          sent;
      req_valid  = 1'b0;
      req_action = ACT_ADD;
      req_p_x    = '0;
      req_p_y    = '0;
      req_p_inf  = 1'b0;
      req_q_x    = '0;
      req_q_y    = '0;
      req_q_inf  = 1'b0;
      req_scalar = '0;
      stim_done  = 1'b0;
      reset      = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed corners
      foreach (dir_tab[i]) begin
         drive_word(dir_tab[i].w,
            dir_tab[i].chk ? dir_tab[i].r : predict_point(dir_tab[i].w));
         if ($urandom_range(0, 2) == 0) idle_sender(int'($urandom_range(1, 4)));
      end

      // random words in bursts
      sent = 0;
      while (sent < 100) begin
         burst = int'($urandom_range(1, 6));
         repeat (burst) begin
            w = random_word();
            drive_word(w, predict_point(w));
            sent++;
         end
         if ($urandom_range(0, 3) != 0) idle_sender(int'($urandom_range(1, 30)));
      end
      idle_sender(1);
      stim_done = 1'b1;
   end

   // ---------------- receiver and checker ----------------
   // Stall pattern: alternate free-running stretches with random backpressure.
   initial begin
      int phase;
      rsp_ready = 1'b0;
      phase     = 0;
      forever begin
         @(negedge clock);
         phase++;
         if (phase[9]) rsp_ready = 1'b1;
         else          rsp_ready = ($urandom_range(0, 3) != 0);
      end
   end

   task automatic report_mismatch(string what, fld_type got, fld_type want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      err_count++;
   endtask

   initial begin
      point_res_type want;
      err_count = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected word", rsp_r_x, '0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_r_x   !== want.x)     report_mismatch("r_x", rsp_r_x, want.x);
               if (rsp_r_y   !== want.y)     report_mismatch("r_y", rsp_r_y, want.y);
               if (rsp_r_inf !== want.inf)
                  report_mismatch("r_inf", FLD_BITS'(rsp_r_inf), FLD_BITS'(want.inf));
               if (rsp_fault !== want.fault)
                  report_mismatch("fault", FLD_BITS'(rsp_fault), FLD_BITS'(want.fault));
            end
         end
      end
   end

   // ---------------- end of run ----------------
   initial begin
      wait (stim_done);
      while (pending_results.size() != 0) @(posedge clock);
      // drain: let any stray word show up
      repeat (2000) @(posedge clock);
      if (err_count == 0) $display("binary_koblitz_point_arithmetic_tb OK");
      else                $display("binary_koblitz_point_arithmetic_tb NOT OK");
      $finish;
   end

   initial begin
      #200ms;
      $display("binary_koblitz_point_arithmetic_tb NOT OK");
      $finish;
   end

endmodule

[binary_koblitz_point_arithmetic.f]
+incdir+rtl
rtl/bkpa_pkg.sv
rtl/bkpa_mul.sv
rtl/binary_koblitz_point_arithmetic.sv
sim/binary_koblitz_point_arithmetic_tb.sv
